/* hw/rtl/fixed_capacity_list_engine_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-capacity list engine.
// Each macro expands to one labeled concurrent assertion on clk with reset.
// ---------------------------------------------------------------------------
`ifndef FIXED_CAPACITY_LIST_ENGINE_CORE_ASSERT_SVH
`define FIXED_CAPACITY_LIST_ENGINE_CORE_ASSERT_SVH

// Condition in the same cycle.
`define FLC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition in the following cycle.
`define FLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/flc_pkg.sv */
// ---------------------------------------------------------------------------
// flc_pkg
// Shared constants, codes and types of the fixed-capacity list engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package flc_pkg;

  // Storage geometry.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Port field widths.
  localparam int FIELD_W = 5;
  localparam int VALUE_W = 32;
  localparam int CMD_W   = 3;

  // Counts and slot indexes hold 0..CAPACITY.
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // Range checks are done wide enough for both the fields and the counts.
  localparam int WIDE_W = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_FILL   = 3'd4
  } cmd_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    C_NONE,
    C_INSERT,
    C_FILL,
    C_LOAD,
    C_SHIFT,
    C_COMMIT,
    C_FIND
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [CNT_W-1:0]      lo;
    logic [CNT_W-1:0]      hi;
    logic [DATA_WIDTH-1:0] value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERASE,
    ST_FIND,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic [FIELD_W-1:0] where;
    logic [FIELD_W-1:0] fill_count;
    logic               fault;
  } res_t;

endpackage

/* hw/rtl/fixed_capacity_list_engine_core.sv */
// ---------------------------------------------------------------------------
// fixed_capacity_list_engine_core
// Fixed-capacity ordered list held in a row of slot cells with a fill count.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Words carried
//  in       in_valid / in_ready   cmd, pos, span, stop, value
//  out      out_valid / out_ready data, where, fill_count, fault
//
//  Read, insert, fill and rejected words are answered from the idle state;
//  find registers the match flags, then encodes them. Erase loads the shadow
//  row, moves it down one slot per cycle over span slots, then writes it back.
//  A new word is taken while a result waits in the output register, but not
//  during erase or find, nor while a second result waits on an unread first.
//  Reset clears the fill count and control; entries are undefined until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_capacity_list_engine_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [flc_pkg::CMD_W-1:0]   cmd,
  input  logic [flc_pkg::FIELD_W-1:0] pos,
  input  logic [flc_pkg::FIELD_W-1:0] span,
  input  logic [flc_pkg::FIELD_W-1:0] stop,
  input  logic [flc_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [flc_pkg::VALUE_W-1:0] data,
  output logic [flc_pkg::FIELD_W-1:0] where,
  output logic [flc_pkg::FIELD_W-1:0] fill_count,
  output logic                        fault
);
  import flc_pkg::*;

  `include "fixed_capacity_list_engine_core_assert.svh"

  state_t           state, state_next;
  logic [CNT_W-1:0] vc, vc_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] lo_r, lo_next;
  logic [CNT_W-1:0] hi_r, hi_next;
  res_t             pend;
  res_t             out_reg;
  res_t             res;
  logic             finish;
  logic             out_free;
  cell_ctl_t        ctl;

  logic [DATA_WIDTH-1:0] entry_w  [CAPACITY];
  logic [DATA_WIDTH-1:0] shadow_w [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_w     [CAPACITY];
  logic [CAPACITY-1:0]   hit_w;
  logic [DATA_WIDTH-1:0] rd_or;
  logic [CNT_W-1:0]      enc_where;

  logic [WIDE_W-1:0] pos_w, span_w, stop_w, vc_w, cap_w;

  assign pos_w  = WIDE_W'(pos);
  assign span_w = WIDE_W'(span);
  assign stop_w = WIDE_W'(stop);
  assign vc_w   = WIDE_W'(vc);
  assign cap_w  = WIDE_W'(CAPACITY);

  // Row of slot cells; entries move up from the lower neighbor on insert,
  // shadows move down from the upper neighbor during erase.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = shadow_w[i+1];
    end
    flc_cell u_cell (
      .clk          (clk),
      .idx          (CNT_W'(i)),
      .ctl          (ctl),
      .lower_entry  (lower),
      .upper_shadow (upper),
      .entry        (entry_w[i]),
      .shadow       (shadow_w[i]),
      .rd_data      (rd_w[i]),
      .hit          (hit_w[i])
    );
  end

  // Read bus: only the addressed cell drives nonzero data.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_w[i];
    end
  end

  flc_hit_enc u_hit_enc (
    .hit   (hit_w),
    .stop  (hi_r),
    .where (enc_where)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Command decode, cell control and next state.
  always_comb begin
    state_next = state;
    vc_next    = vc;
    cnt_next   = cnt;
    lo_next    = lo_r;
    hi_next    = hi_r;
    finish     = 1'b0;
    res        = '0;
    ctl.op     = C_NONE;
    ctl.lo     = lo_r;
    ctl.hi     = hi_r;
    ctl.value  = value[DATA_WIDTH-1:0];

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(cmd))
            CMD_READ: begin
              finish = 1'b1;
              if (pos_w >= cap_w) begin
                res.fault = 1'b1;
              end else begin
                ctl.lo   = CNT_W'(pos);
                res.data = VALUE_W'(rd_or);
              end
            end
            CMD_INSERT: begin
              finish = 1'b1;
              if (pos_w > vc_w) begin
                res.fault = 1'b1;
              end else if (vc_w >= cap_w) begin
                // Full list: the last entry drops out.
                ctl.op = C_INSERT;
                ctl.hi = CNT_W'(CAPACITY - 1);
                if (pos_w >= cap_w) begin
                  ctl.lo    = CNT_W'(CAPACITY - 1);
                  res.where = FIELD_W'(CAPACITY - 1);
                end else begin
                  ctl.lo    = CNT_W'(pos);
                  res.where = pos;
                end
              end else begin
                ctl.op    = C_INSERT;
                ctl.lo    = CNT_W'(pos);
                ctl.hi    = vc;
                vc_next   = vc + CNT_W'(1);
                res.where = pos;
              end
            end
            CMD_ERASE: begin
              if ((pos_w + span_w) > vc_w) begin
                finish    = 1'b1;
                res.fault = 1'b1;
              end else begin
                ctl.op     = C_LOAD;
                lo_next    = CNT_W'(pos);
                hi_next    = CNT_W'(vc_w - span_w);
                cnt_next   = CNT_W'(span);
                state_next = ST_ERASE;
              end
            end
            CMD_FIND: begin
              if ((pos_w > stop_w) || (stop_w > cap_w)) begin
                finish    = 1'b1;
                res.fault = 1'b1;
              end else begin
                ctl.op     = C_FIND;
                ctl.lo     = CNT_W'(pos);
                ctl.hi     = CNT_W'(stop);
                hi_next    = CNT_W'(stop);
                state_next = ST_FIND;
              end
            end
            CMD_FILL: begin
              ctl.op = C_FILL;
              finish = 1'b1;
            end
            default: begin
              finish    = 1'b1;
              res.fault = 1'b1;
            end
          endcase
        end
      end
      ST_ERASE: begin
        if (cnt != '0) begin
          ctl.op   = C_SHIFT;
          cnt_next = cnt - CNT_W'(1);
        end else begin
          // Write the shifted words back and shrink the list.
          ctl.op  = C_COMMIT;
          vc_next = hi_r;
          finish  = 1'b1;
        end
      end
      ST_FIND: begin
        res.where = FIELD_W'(enc_where);
        finish    = 1'b1;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.fill_count = FIELD_W'(vc_next);

    if (finish) begin
      state_next = out_free ? ST_IDLE : ST_HOLD;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vc    <= '0;
    end else begin
      state <= state_next;
      vc    <= vc_next;
    end
  end

  // Sequencing registers for erase and find.
  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    lo_r <= lo_next;
    hi_r <= hi_next;
  end

  // Output register and the pending result behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_HOLD) && out_free) begin
      out_valid <= 1'b1;
    end else if (finish && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_HOLD) && out_free) begin
      out_reg <= pend;
    end else if (finish && out_free) begin
      out_reg <= res;
    end
    if (finish && !out_free) begin
      pend <= res;
    end
  end

  assign data       = out_reg.data;
  assign where      = out_reg.where;
  assign fill_count = out_reg.fill_count;
  assign fault      = out_reg.fault;

  // Checks on the engine's own bookkeeping.
  `FLC_ASSERT_SAME(a_count_range, clk, rst, 1'b1, vc <= CNT_W'(CAPACITY), "fill count above capacity")
  `FLC_ASSERT_SAME(a_hold_has_out, clk, rst, state == ST_HOLD, out_valid, "pending result without an occupied output register")
  `FLC_ASSERT_NEXT(a_erase_ends, clk, rst, (state == ST_ERASE) && (cnt == '0), (state == ST_IDLE) || (state == ST_HOLD), "erase did not finish after its last shift")
  `FLC_ASSERT_SAME(a_fault_clean, clk, rst, out_valid && fault, (data == '0) && (where == '0), "rejected command returned data or a slot")

endmodule

/* hw/rtl/flc_cell.sv */
// ---------------------------------------------------------------------------
// flc_cell
// One slot of the list: the stored entry, a shadow word that shifts toward
// lower slots during erase, and a registered match flag for find.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module flc_cell (
  input  logic                          clk,
  input  logic [flc_pkg::CNT_W-1:0]     idx,
  input  flc_pkg::cell_ctl_t            ctl,
  input  logic [flc_pkg::DATA_WIDTH-1:0] lower_entry,
  input  logic [flc_pkg::DATA_WIDTH-1:0] upper_shadow,
  output logic [flc_pkg::DATA_WIDTH-1:0] entry,
  output logic [flc_pkg::DATA_WIDTH-1:0] shadow,
  output logic [flc_pkg::DATA_WIDTH-1:0] rd_data,
  output logic                          hit
);
  import flc_pkg::*;

  logic at_lo;
  logic above_lo;
  logic in_range;

  // Position of this slot relative to the broadcast window.
  assign at_lo    = (idx == ctl.lo);
  assign above_lo = (idx > ctl.lo) && (idx <= ctl.hi);
  assign in_range = (idx >= ctl.lo) && (idx < ctl.hi);

  // The selected slot drives the read bus, all others drive zero.
  assign rd_data = entry & {DATA_WIDTH{at_lo}};

  // Stored entry.
  always_ff @(posedge clk) begin
    case (ctl.op)
      C_INSERT: begin
        if (at_lo) begin
          entry <= ctl.value;
        end else if (above_lo) begin
          entry <= lower_entry;
        end
      end
      C_FILL: begin
        entry <= ctl.value;
      end
      C_COMMIT: begin
        if (in_range) begin
          entry <= shadow;
        end
      end
      default: begin
      end
    endcase
  end

  // Shadow word: copied from the entry, then moved down one slot a cycle.
  always_ff @(posedge clk) begin
    case (ctl.op)
      C_LOAD:  shadow <= entry;
      C_SHIFT: shadow <= upper_shadow;
      default: begin
      end
    endcase
  end

  // Match flag for the find window.
  always_ff @(posedge clk) begin
    if (ctl.op == C_FIND) begin
      hit <= in_range && (entry == ctl.value);
    end
  end

endmodule

/* hw/rtl/flc_hit_enc.sv */
// ---------------------------------------------------------------------------
// flc_hit_enc
// Turns the row of match flags into the lowest matching slot, or the end
// of the search window when no slot matched.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module flc_hit_enc (
  input  logic [flc_pkg::CAPACITY-1:0] hit,
  input  logic [flc_pkg::CNT_W-1:0]    stop,
  output logic [flc_pkg::CNT_W-1:0]    where
);
  import flc_pkg::*;

  logic [CAPACITY-1:0] first;
  logic [CNT_W-1:0]    slot;

  // Isolate the lowest set flag.
  assign first = hit & (~hit + CAPACITY'(1));

  // Encode the one-hot flag as a slot number.
  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      slot = slot | ({CNT_W{first[i]}} & CNT_W'(i));
    end
  end

  assign where = (hit == '0) ? stop : slot;

endmodule
